[sv/tssq_pkg.sv]
// Package for the time sync request sequencer: item types, step codes and constants.
`default_nettype none

package tssq_pkg;

  localparam int unsigned HANDLE_PERIOD_MS_DEF = 10;

  localparam logic [31:0] EPOCH_OFFSET         = 32'd2208988800;
  localparam logic [31:0] REPLY_TIMEOUT_MS     = 32'd5000;
  localparam logic [31:0] RETRY_WAIT_MS        = 32'd7001;
  localparam logic [31:0] SECOND_MS            = 32'd1000;
  localparam logic [31:0] MIN_INTERVAL_MS      = 32'd120000;
  localparam logic [31:0] SYNC_INTERVAL_RESET  = 32'd82800000;

  typedef enum logic [2:0] {
    ST_INIT          = 3'd0,
    ST_START         = 3'd1,
    ST_SEND          = 3'd2,
    ST_WAIT_REPLY    = 3'd3,
    ST_WAIT_INTERVAL = 3'd4,
    ST_COMPLETE      = 3'd5,
    ST_ERROR         = 3'd6,
    ST_RETRY         = 3'd7
  } step_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        link_up;
    logic        udp_begin_ok;
    logic        send_ok;
    logic        response_valid;
    logic [31:0] response_ntp_seconds;
    logic        force_sync;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  step_code;
    logic        healthy;
    logic [31:0] unix_time;
    logic        poll_active;
    logic        start_socket;
    logic        send_request;
    logic        stop_socket;
  } out_item_t;

endpackage

`default_nettype wire

[sv/tssq_in_stage.sv]
// Input register stage holding one accepted poll until the step logic consumes it.
`default_nettype none

module tssq_in_stage
  import tssq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  input  wire logic     take,
  output logic          item_valid,
  output in_item_t      item
);

  assign in_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

endmodule

`default_nettype wire

[sv/tssq_seq.sv]
// Sequencer state, timers and the single-pass step logic for one poll.
`default_nettype none

module tssq_seq
  import tssq_pkg::*;
#(
  parameter int unsigned HANDLE_PERIOD_MS = HANDLE_PERIOD_MS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_value,
  input  wire logic        fire,
  input  wire in_item_t    item,
  output out_item_t        result
);

  logic [31:0] sync_interval_ms;
  step_t       cur_step, cur_step_next;
  step_t       cmd_step, cmd_step_next;
  logic        ret_init, ret_init_next;
  logic        link_lost_done, link_lost_done_next;
  logic        force_latch, force_latch_next;
  logic [31:0] last_poll_ms, last_poll_ms_next;
  logic [31:0] second_mark_ms, second_mark_ms_next;
  logic [31:0] reply_timer_ms, reply_timer_ms_next;
  logic [31:0] retry_timer_ms, retry_timer_ms_next;
  logic [31:0] interval_timer_ms, interval_timer_ms_next;
  logic        synced, synced_next;
  logic [31:0] unix_now, unix_now_next;

  logic        active, tick, frc, sync_now;
  logic        s_start, s_send, s_stop;
  logic [31:0] ux;

  always_comb begin
    cur_step_next          = cur_step;
    cmd_step_next          = cmd_step;
    ret_init_next          = ret_init;
    link_lost_done_next    = link_lost_done;
    force_latch_next       = force_latch;
    last_poll_ms_next      = last_poll_ms;
    second_mark_ms_next    = second_mark_ms;
    reply_timer_ms_next    = reply_timer_ms;
    retry_timer_ms_next    = retry_timer_ms;
    interval_timer_ms_next = interval_timer_ms;
    synced_next            = synced;
    unix_now_next          = unix_now;
    s_start                = 1'b0;
    s_send                 = 1'b0;
    s_stop                 = 1'b0;
    sync_now               = 1'b0;

    active = (item.now_ms - last_poll_ms) >= 32'(HANDLE_PERIOD_MS);
    tick   = (item.now_ms - second_mark_ms) >= SECOND_MS;
    frc    = force_latch || item.force_sync;
    ux     = item.response_ntp_seconds - EPOCH_OFFSET;

    if (active) begin
      if (tick) begin
        second_mark_ms_next = second_mark_ms + SECOND_MS;
      end

      if (item.link_up) begin
        link_lost_done_next = 1'b0;
        cur_step_next = (frc && cur_step == ST_WAIT_INTERVAL) ? ST_COMPLETE : cmd_step;
        cmd_step_next = cur_step_next;

        unique case (cur_step_next)
          ST_INIT: begin
            s_start = 1'b1;
            if (item.udp_begin_ok) begin
              cmd_step_next = ST_START;
            end else begin
              ret_init_next = 1'b1;
              cmd_step_next = ST_ERROR;
            end
          end
          ST_START: begin
            cmd_step_next = ST_SEND;
          end
          ST_SEND: begin
            s_send = 1'b1;
            if (item.send_ok) begin
              cmd_step_next       = ST_WAIT_REPLY;
              reply_timer_ms_next = item.now_ms;
            end else begin
              cmd_step_next = ST_ERROR;
            end
          end
          ST_WAIT_REPLY: begin
            if (item.response_valid && ux != 32'd0) begin
              sync_now               = 1'b1;
              interval_timer_ms_next = item.now_ms;
              cmd_step_next          = ST_WAIT_INTERVAL;
              s_stop                 = 1'b1;
            end
            if ((item.now_ms - reply_timer_ms) > REPLY_TIMEOUT_MS) begin
              cmd_step_next = ST_ERROR;
            end
          end
          ST_WAIT_INTERVAL: begin
            if ((item.now_ms - interval_timer_ms) > sync_interval_ms) begin
              cmd_step_next = ST_COMPLETE;
            end
          end
          ST_COMPLETE: begin
            cmd_step_next = ST_INIT;
          end
          ST_ERROR: begin
            retry_timer_ms_next = item.now_ms;
            cmd_step_next       = ST_RETRY;
          end
          ST_RETRY: begin
            if ((item.now_ms - retry_timer_ms) > RETRY_WAIT_MS) begin
              cmd_step_next = ret_init ? ST_INIT : ST_START;
              ret_init_next = 1'b0;
            end
          end
          default: begin
            cmd_step_next = ST_INIT;
          end
        endcase
      end else if (!link_lost_done) begin
        s_stop              = 1'b1;
        cur_step_next       = ST_INIT;
        cmd_step_next       = ST_INIT;
        ret_init_next       = 1'b0;
        link_lost_done_next = 1'b1;
      end

      // Unix time advances with the second tick once a reply has been taken.
      if (sync_now) begin
        synced_next   = 1'b1;
        unix_now_next = ux;
      end else if (synced && tick) begin
        unix_now_next = unix_now + 32'd1;
      end

      force_latch_next  = 1'b0;
      last_poll_ms_next = item.now_ms;
    end else if (item.force_sync) begin
      force_latch_next = 1'b1;
    end

    result.step_code    = cur_step_next;
    result.healthy      = (cur_step_next != ST_ERROR);
    result.unix_time    = unix_now_next;
    result.poll_active  = active;
    result.start_socket = s_start;
    result.send_request = s_send;
    result.stop_socket  = s_stop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_interval_ms <= SYNC_INTERVAL_RESET;
    end else if (cfg_we) begin
      sync_interval_ms <= (cfg_value < MIN_INTERVAL_MS) ? MIN_INTERVAL_MS : cfg_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_step          <= ST_INIT;
      cmd_step          <= ST_INIT;
      ret_init          <= 1'b0;
      link_lost_done    <= 1'b0;
      force_latch       <= 1'b0;
      last_poll_ms      <= '0;
      second_mark_ms    <= '0;
      reply_timer_ms    <= '0;
      retry_timer_ms    <= '0;
      interval_timer_ms <= '0;
      synced            <= 1'b0;
      unix_now          <= '0;
    end else if (fire) begin
      cur_step          <= cur_step_next;
      cmd_step          <= cmd_step_next;
      ret_init          <= ret_init_next;
      link_lost_done    <= link_lost_done_next;
      force_latch       <= force_latch_next;
      last_poll_ms      <= last_poll_ms_next;
      second_mark_ms    <= second_mark_ms_next;
      reply_timer_ms    <= reply_timer_ms_next;
      retry_timer_ms    <= retry_timer_ms_next;
      interval_timer_ms <= interval_timer_ms_next;
      synced            <= synced_next;
      unix_now          <= unix_now_next;
    end
  end

endmodule

`default_nettype wire

[sv/tssq_out_stage.sv]
// Result register stage presenting one result until the downstream side takes it.
`default_nettype none

module tssq_out_stage
  import tssq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      load,
  input  wire out_item_t result,
  output logic           can_load,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

[sv/time_sync_request_sequencer.sv]
// Path: a poll accepted into the input register passes through the step logic into the
// result register, from which its result is handed downstream.
// Throughput: one poll per cycle while the result register is not stalled; the step
// logic does the whole poll in one pass, so state is ready for the next one.
// A stalled result register holds one result while the input register holds the next.
// Reset (rst, synchronous): sequencer back to init, all timers and the time zero,
// sync interval back to its default; both registers empty.
`default_nettype none

module time_sync_request_sequencer
  import tssq_pkg::*;
#(
  parameter int unsigned HANDLE_PERIOD_MS = HANDLE_PERIOD_MS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  // The configuration channel is always ready. The host must write the sync interval
  // only while no poll is in flight; the block does not enforce it or order writes.
  assign cfg_ready = 1'b1;

  logic      item_valid;
  in_item_t  item;
  logic      can_load;
  logic      fire;
  out_item_t result;

  // A poll moves from the input register into the result register in one step. The
  // sequencer state is updated in the same cycle, so the poll behind it sees the new
  // state on the very next clock.
  assign fire = item_valid && can_load;

  tssq_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (can_load),
    .item_valid (item_valid),
    .item       (item)
  );

  tssq_seq #(
    .HANDLE_PERIOD_MS (HANDLE_PERIOD_MS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_value (cfg_data),
    .fire      (fire),
    .item      (item),
    .result    (result)
  );

  // The result register decouples the downstream stall from the input side: a new
  // transfer is accepted while a finished result still waits to be taken.
  tssq_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (item_valid),
    .result    (result),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTH
  // An accepted poll is always in the input register on the next cycle.
  a_in_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> item_valid)
    else $error("accepted poll did not reach the input register");

  // Action strobes only come from a poll that acted.
  a_strobe_active: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.start_socket || out_data.send_request || out_data.stop_socket))
      |-> out_data.poll_active)
    else $error("strobe on an inactive poll");

  // Start and send are attempted in different steps, never in the same poll.
  a_start_send: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.start_socket && out_data.send_request))
    else $error("start and send strobed together");

  // Health tracks the error step.
  a_healthy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.healthy == (out_data.step_code != ST_ERROR)))
    else $error("healthy does not match step code");
`endif

endmodule

`default_nettype wire
